// File: design/brde_pkg.sv
`timescale 1ns / 1ps

package brde_pkg;

    localparam int unsigned IN_ROW_BITS = 32;
    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned WAIT_BITS   = 16;

    typedef struct packed {
        logic                   action;
        logic [IN_ROW_BITS-1:0] row_bits;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 last_of_run;
    } t_out_beat;

    localparam logic ACT_ROW    = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    function automatic logic [2:0] popcount4(input logic [3:0] nib);
        popcount4 = 3'(nib[0]) + 3'(nib[1]) + 3'(nib[2]) + 3'(nib[3]);
    endfunction

endpackage

// File: design/bitmap_row_delta_encoder.sv
`timescale 1ns / 1ps
// Row delta encoder for a one-bit bitmap.
// Input channel (i_in_valid / o_in_ready / i_in_beat): one row or a finish beat.
// Output channel (o_out_valid / i_out_ready / o_out_beat): one stream byte per beat.
// The first row sends its set-pixel count and the set columns. Later rows send
// wait, change count and changed columns, or only bump wait when equal. A finish
// beat compares last row against first, sends a zero byte with last_of_run set
// and clears the run state.
// Steps: a row is accepted, then its set or changed bits are counted nibble by nibble
// through the shared nibble adder; when it changes, the wait and change-count header bytes
// follow and then W column scan steps, one column per cycle while no changed column waits
// on a stalled output, where W = min(ROW_WIDTH, 32). A first row sends its count byte with
// no wait byte. A finish ends with the terminator, sent straight away when no row was seen.
// o_in_ready is high only while the sequencer is idle.
// Bytes leave through an output register; a stalled receiver holds the sequencer
// at its next byte while the scan waits, nothing is dropped.
// Reset (synchronous, active low) clears rows, sets wait to 1 and empties output.
module bitmap_row_delta_encoder #(
    parameter int unsigned ROW_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  brde_pkg::t_in_beat i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output brde_pkg::t_out_beat o_out_beat
);
    import brde_pkg::*;

    localparam int unsigned EW     = (ROW_WIDTH < IN_ROW_BITS) ? ROW_WIDTH : IN_ROW_BITS;
    localparam int unsigned NIB    = (EW + 3) / 4;
    localparam int unsigned SCAN_W = NIB * 4;
    localparam int unsigned NIBW   = (NIB > 1) ? $clog2(NIB) : 1;
    localparam int unsigned CW     = $clog2(EW + 1);
    localparam int unsigned COLW   = $clog2(EW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_WAIT,
        S_AMT,
        S_SCAN,
        S_TERM
    } t_state;

    t_state                r_state;
    logic [EW-1:0]         r_first;
    logic [EW-1:0]         r_prev;
    logic [WAIT_BITS-1:0]  r_wait;
    logic                  r_seen;
    logic                  r_fin;
    logic                  r_first_mode;
    logic [EW-1:0]         r_diff;
    logic [SCAN_W-1:0]     r_scan;
    logic [NIBW-1:0]       r_nib;
    logic [CW-1:0]         r_cnt;
    logic [COLW-1:0]       r_col;

    logic [EW-1:0]         w_row;
    logic [EW-1:0]         w_diff;
    logic [CW-1:0]         n_cnt;
    logic                  w_nib_last;
    logic                  w_free;
    logic                  s_load;
    t_out_beat             s_beat;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_row      = i_in_beat.row_bits[EW-1:0];
    assign w_diff     = (i_in_beat.action == ACT_FINISH) ? (r_prev ^ r_first) :
                        (r_seen ? (r_prev ^ w_row) : w_row);
    assign n_cnt      = r_cnt + CW'(popcount4(r_scan[3:0]));
    assign w_nib_last = (r_nib == NIBW'(NIB - 1));

    always_comb begin
        s_load = 1'b0;
        s_beat = '0;
        unique case (r_state)
            S_WAIT: begin
                s_load          = w_free;
                s_beat.out_byte = r_wait[BYTE_BITS-1:0];
            end
            S_AMT: begin
                s_load          = w_free;
                s_beat.out_byte = BYTE_BITS'(r_cnt);
            end
            S_SCAN: begin
                s_load          = w_free && r_diff[0];
                s_beat.out_byte = BYTE_BITS'(r_col);
            end
            S_TERM: begin
                s_load             = w_free;
                s_beat.last_of_run = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= '0;
            r_prev  <= '0;
            r_wait  <= WAIT_BITS'(1);
            r_seen  <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_scan       <= SCAN_W'(w_diff);
                        r_diff       <= w_diff;
                        r_cnt        <= '0;
                        r_nib        <= '0;
                        r_first_mode <= 1'b0;
                        if (i_in_beat.action == ACT_ROW) begin
                            r_fin   <= 1'b0;
                            r_prev  <= w_row;
                            r_state <= S_COUNT;
                            if (!r_seen) begin
                                r_first_mode <= 1'b1;
                                r_first      <= w_row;
                                r_seen       <= 1'b1;
                            end
                        end else begin
                            r_fin   <= 1'b1;
                            r_state <= r_seen ? S_COUNT : S_TERM;
                        end
                    end
                end
                S_COUNT: begin
                    r_cnt  <= n_cnt;
                    r_scan <= r_scan >> 4;
                    r_nib  <= r_nib + NIBW'(1);
                    if (w_nib_last) begin
                        if (r_first_mode) begin
                            r_state <= S_AMT;
                        end else if (n_cnt == '0) begin
                            r_wait  <= r_wait + WAIT_BITS'(1);
                            r_state <= r_fin ? S_TERM : S_IDLE;
                        end else begin
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (w_free) begin
                        r_wait  <= WAIT_BITS'(1);
                        r_state <= S_AMT;
                    end
                end
                S_AMT: begin
                    if (w_free) begin
                        r_col <= '0;
                        if (r_cnt != '0) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= r_fin ? S_TERM : S_IDLE;
                        end
                    end
                end
                S_SCAN: begin
                    if (!r_diff[0] || w_free) begin
                        r_diff <= r_diff >> 1;
                        r_col  <= r_col + COLW'(1);
                        if (r_col == COLW'(EW - 1)) begin
                            r_state <= r_fin ? S_TERM : S_IDLE;
                        end
                    end
                end
                S_TERM: begin
                    if (w_free) begin
                        r_first <= '0;
                        r_prev  <= '0;
                        r_wait  <= WAIT_BITS'(1);
                        r_seen  <= 1'b0;
                        r_fin   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    brde_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s_load),
        .i_beat  (s_beat),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_beat  (o_out_beat),
        .o_free  (w_free)
    );

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.last_of_run |-> o_out_beat.out_byte == '0)
        else $error("terminator beat carries a nonzero byte");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("sequencer ready again right after an accepted beat");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COUNT && w_nib_last |-> n_cnt <= CW'(EW))
        else $error("change count exceeds row width");

    a_scan_has_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_cnt != '0)
        else $error("column scan entered with zero changes");

endmodule

// File: design/brde_out_reg.sv
`timescale 1ns / 1ps

module brde_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  brde_pkg::t_out_beat i_beat,
    input  logic                i_ready,
    output logic                o_valid,
    output brde_pkg::t_out_beat o_beat,
    output logic                o_free
);
    import brde_pkg::*;

    logic      r_valid;
    t_out_beat r_beat;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_beat <= i_beat;
        end
    end

endmodule

// File: verif/brde_checker.sv
`timescale 1ns / 1ps

module brde_checker #(
    parameter int unsigned ROW_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  brde_pkg::t_in_beat  i_in_beat,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  brde_pkg::t_out_beat i_out_beat,
    output int                  o_fail_count,
    output int                  o_pending
);
    import brde_pkg::*;

    localparam int unsigned SCAN_COLS = (ROW_WIDTH < IN_ROW_BITS) ? ROW_WIDTH : IN_ROW_BITS;
    localparam logic [IN_ROW_BITS-1:0] COL_MASK =
        (ROW_WIDTH >= IN_ROW_BITS) ? '1 : ((IN_ROW_BITS'(1) << ROW_WIDTH) - 1);
    localparam int REPORT_LIMIT = 10;

    t_out_beat               stream_bytes[$];
    logic [IN_ROW_BITS-1:0]  first_row;
    logic [IN_ROW_BITS-1:0]  prev_row;
    logic [WAIT_BITS-1:0]    wait_cnt;
    bit                      have_row;
    int                      mismatches;
    int                      beats_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
        beats_seen   = 0;
    end

    task automatic push_byte(input logic [BYTE_BITS-1:0] b, input logic last);
        t_out_beat e;
        e.out_byte    = b;
        e.last_of_run = last;
        stream_bytes.push_back(e);
    endtask

    task automatic push_columns(input logic [IN_ROW_BITS-1:0] bits);
        for (int x = 0; x < SCAN_COLS; x++) begin
            if (bits[x]) begin
                push_byte(BYTE_BITS'(x), 1'b0);
            end
        end
    endtask

    task automatic diff_rows(input logic [IN_ROW_BITS-1:0] older,
                             input logic [IN_ROW_BITS-1:0] newer);
        logic [IN_ROW_BITS-1:0] changed;
        int                     amount;
        changed = (older ^ newer) & COL_MASK;
        amount  = $countones(changed);
        if (amount > 0) begin
            push_byte(wait_cnt[BYTE_BITS-1:0], 1'b0);
            push_byte(BYTE_BITS'(amount), 1'b0);
            push_columns(changed);
            wait_cnt = WAIT_BITS'(1);
        end else begin
            wait_cnt = wait_cnt + WAIT_BITS'(1);
        end
    endtask

    task automatic clear_run();
        first_row = '0;
        prev_row  = '0;
        wait_cnt  = WAIT_BITS'(1);
        have_row  = 1'b0;
    endtask

    task automatic encode_beat(input t_in_beat b);
        logic [IN_ROW_BITS-1:0] row;
        row = b.row_bits & COL_MASK;
        if (b.action == ACT_ROW) begin
            if (!have_row) begin
                push_byte(BYTE_BITS'($countones(row)), 1'b0);
                push_columns(row);
                first_row = row;
                have_row  = 1'b1;
            end else begin
                diff_rows(prev_row, row);
            end
            prev_row = row;
        end else begin
            if (have_row) begin
                diff_rows(prev_row, first_row);
            end
            push_byte('0, 1'b1);
            clear_run();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            stream_bytes.delete();
            clear_run();
        end else begin
            if (i_out_valid && i_out_ready) begin
                beats_seen++;
                if (stream_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected beat %0d: byte %0d last %0b",
                                 beats_seen, i_out_beat.out_byte, i_out_beat.last_of_run);
                    end
                end else begin
                    want = stream_bytes.pop_front();
                    if (want.out_byte !== i_out_beat.out_byte ||
                        want.last_of_run !== i_out_beat.last_of_run) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("beat %0d: expected byte %0d last %0b, got byte %0d last %0b",
                                     beats_seen, want.out_byte, want.last_of_run,
                                     i_out_beat.out_byte, i_out_beat.last_of_run);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                encode_beat(i_in_beat);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= stream_bytes.size();
    end

endmodule

// File: verif/bitmap_row_delta_encoder_test.sv
`timescale 1ns / 1ps

module bitmap_row_delta_encoder_test;
    import brde_pkg::*;

    localparam int unsigned ROW_WIDTH   = 32;
    localparam int          RANDOM_BEATS = 106;
    localparam int          IDLE_LIMIT  = 4000;
    localparam int          LONG_HOLD   = 600;
    localparam int          HOLD_AFTER  = 200;
    localparam int          TAIL_CYCLES = 100;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_ready;
    t_out_beat out_beat;
    int        fail_count;
    int        pending;
    int        beats_taken;
    int        idle_cycles;
    int        sender_gap_pct;

    bitmap_row_delta_encoder #(
        .ROW_WIDTH(ROW_WIDTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_beat (out_beat)
    );

    brde_checker #(
        .ROW_WIDTH(ROW_WIDTH)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_beat  (out_beat),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial begin
        beats_taken = 0;
        idle_cycles = 0;
    end

    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            beats_taken <= beats_taken + 1;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_beat(input logic act, input logic [IN_ROW_BITS-1:0] row);
        t_in_beat b;
        int       gap;
        gap = 0;
        if ($urandom_range(0, 99) < sender_gap_pct) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        b.action   = act;
        b.row_bits = row;
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [IN_ROW_BITS-1:0] fresh_row();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom() & $urandom() & $urandom();
            3:       return $urandom() | $urandom();
            default: return $urandom();
        endcase
    endfunction

    // receiver: random stalls, one long hold once the stream is going
    initial begin
        int gap_left;
        int hold_left;
        int stall_pct;
        int cyc;
        bit hold_done;
        gap_left  = 0;
        hold_left = 0;
        stall_pct = 0;
        cyc       = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc % 256 == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    2: stall_pct = 40;
                    default: stall_pct = 70;
                endcase
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && beats_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end else if (gap_left > 0) begin
                out_ready <= 1'b0;
                gap_left--;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                       : $urandom_range(0, 2);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [IN_ROW_BITS-1:0] row;
        int                     sent;
        int                     run_len;
        bit                     paused;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_beat        = '0;
        sender_gap_pct = 0;
        sent           = 0;
        paused         = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // finish with no row, then single-row runs
        send_beat(ACT_FINISH, 32'hFFFF_FFFF);
        send_beat(ACT_ROW, 32'h0000_0000);
        send_beat(ACT_FINISH, 32'h0000_0000);
        send_beat(ACT_ROW, 32'hA5A5_5A5A);
        send_beat(ACT_FINISH, 32'h5A5A_A5A5);
        // all columns, equal rows, full flip, edge columns, wrap compare
        send_beat(ACT_ROW, 32'hFFFF_FFFF);
        send_beat(ACT_ROW, 32'hFFFF_FFFF);
        send_beat(ACT_ROW, 32'h0000_0000);
        send_beat(ACT_ROW, 32'h8000_0001);
        send_beat(ACT_ROW, 32'h8000_0001);
        send_beat(ACT_ROW, 32'h8000_0001);
        send_beat(ACT_ROW, 32'h7FFF_FFFE);
        send_beat(ACT_FINISH, 32'h0000_0000);
        // wait count past 8 bits
        send_beat(ACT_ROW, 32'h0000_0001);
        repeat (258) send_beat(ACT_ROW, 32'h0000_0001);
        send_beat(ACT_ROW, 32'h0000_0002);
        send_beat(ACT_FINISH, 32'h0000_0000);
        wait_drained();

        while (sent < RANDOM_BEATS) begin
            if ($urandom_range(0, 3) == 0) begin
                sender_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
            row = fresh_row();
            for (int k = 0; k < run_len; k++) begin
                send_beat(ACT_ROW, row);
                sent++;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: ;
                    4, 5: row = row ^ (IN_ROW_BITS'(1) << $urandom_range(0, 31));
                    6: row = row ^ (IN_ROW_BITS'(1) << $urandom_range(0, 31))
                                 ^ (IN_ROW_BITS'(1) << $urandom_range(0, 31));
                    7: row = ~row;
                    default: row = fresh_row();
                endcase
            end
            send_beat(ACT_FINISH, $urandom());
            sent++;
            if ($urandom_range(0, 9) == 0) begin
                send_beat(ACT_FINISH, $urandom());
                sent++;
            end
            if (!paused && sent >= RANDOM_BEATS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
